>>> src/obm_pkg.sv
package obm_pkg;

  // Object index carried with each item
  localparam int IDX_W = 8;

  // Quaternion component, signed Q1.14, four packed into the rotation register
  localparam int QW    = 16;
  localparam int ROT_W = 4 * QW;

  // Rotation matrix entry after rounding to units of 2^-16
  localparam int MAT_W = 22;

  // Configuration port
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  // Half-extents are compared in units of 2^-16 of a position step
  localparam int HALF_SHIFT = 16;

  typedef logic signed [MAT_W-1:0] mat_t [3][3];

endpackage

>>> src/obm_cfg_regs.sv
module obm_cfg_regs #(
  parameter int COORD_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [obm_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [obm_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [obm_pkg::CFG_DATA_W-1:0]      prdata,
  output logic signed [COORD_BITS-1:0]        center_x,
  output logic signed [COORD_BITS-1:0]        center_y,
  output logic signed [COORD_BITS-1:0]        center_z,
  output logic [COORD_BITS-2:0]               half_x,
  output logic [COORD_BITS-2:0]               half_y,
  output logic [COORD_BITS-2:0]               half_z,
  output logic [obm_pkg::ROT_W-1:0]           rotation
);
  import obm_pkg::*;

  localparam int SEL_W = CFG_ADDR_W - 3;
  localparam logic [SEL_W-1:0] REG_CENTER_X = SEL_W'(0);
  localparam logic [SEL_W-1:0] REG_CENTER_Y = SEL_W'(1);
  localparam logic [SEL_W-1:0] REG_CENTER_Z = SEL_W'(2);
  localparam logic [SEL_W-1:0] REG_HALF_X   = SEL_W'(3);
  localparam logic [SEL_W-1:0] REG_HALF_Y   = SEL_W'(4);
  localparam logic [SEL_W-1:0] REG_HALF_Z   = SEL_W'(5);
  localparam logic [SEL_W-1:0] REG_ROTATION = SEL_W'(6);

  localparam int                 HW         = COORD_BITS - 1;
  localparam logic [HW-1:0]      HALF_RESET = HW'(128);
  localparam logic [ROT_W-1:0]   ROT_RESET  = {2'b01, {(ROT_W-2){1'b0}}};
  localparam int                 CPAD       = CFG_DATA_W - COORD_BITS;
  localparam int                 HPAD       = CFG_DATA_W - HW;

  logic             wr;
  logic [SEL_W-1:0] sel;

  assign wr  = psel & penable & pwrite;
  assign sel = paddr[CFG_ADDR_W-1:3];

  // Write the addressed register; unknown addresses are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      half_x   <= HALF_RESET;
      half_y   <= HALF_RESET;
      half_z   <= HALF_RESET;
      rotation <= ROT_RESET;
    end else if (wr) begin
      case (sel)
        REG_CENTER_X: center_x <= $signed(pwdata[COORD_BITS-1:0]);
        REG_CENTER_Y: center_y <= $signed(pwdata[COORD_BITS-1:0]);
        REG_CENTER_Z: center_z <= $signed(pwdata[COORD_BITS-1:0]);
        REG_HALF_X:   half_x   <= pwdata[HW-1:0];
        REG_HALF_Y:   half_y   <= pwdata[HW-1:0];
        REG_HALF_Z:   half_z   <= pwdata[HW-1:0];
        REG_ROTATION: rotation <= pwdata[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, centres sign-extended
  always_comb begin
    case (sel)
      REG_CENTER_X: prdata = {{CPAD{center_x[COORD_BITS-1]}}, center_x};
      REG_CENTER_Y: prdata = {{CPAD{center_y[COORD_BITS-1]}}, center_y};
      REG_CENTER_Z: prdata = {{CPAD{center_z[COORD_BITS-1]}}, center_z};
      REG_HALF_X:   prdata = {{HPAD{1'b0}}, half_x};
      REG_HALF_Y:   prdata = {{HPAD{1'b0}}, half_y};
      REG_HALF_Z:   prdata = {{HPAD{1'b0}}, half_z};
      REG_ROTATION: prdata = CFG_DATA_W'(rotation);
      default:      prdata = '0;
    endcase
  end

endmodule

>>> src/obm_rot_matrix.sv
module obm_rot_matrix (
  input  logic                      clk,
  input  logic [obm_pkg::ROT_W-1:0] rotation,
  output obm_pkg::mat_t             mat
);
  import obm_pkg::*;

  localparam int PW          = 2 * QW;
  localparam int SW          = PW + 3;
  localparam int ROUND_SHIFT = 12;
  localparam logic signed [SW-1:0] ROUND_BIAS = SW'(2048);
  localparam logic signed [SW-1:0] DIAG_BIAS  = SW'(268435456) + ROUND_BIAS;

  logic signed [QW-1:0] qw, qx, qy, qz;
  logic signed [PW-1:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;

  function automatic logic signed [SW-1:0] wide(input logic signed [PW-1:0] p);
    return SW'(p);
  endfunction

  // Floor shift of an already biased value: round half up
  function automatic logic signed [MAT_W-1:0] rnd(input logic signed [SW-1:0] v);
    return MAT_W'(v >>> ROUND_SHIFT);
  endfunction

  assign qw = rotation[4*QW-1 -: QW];
  assign qx = rotation[3*QW-1 -: QW];
  assign qy = rotation[2*QW-1 -: QW];
  assign qz = rotation[QW-1 -: QW];

  // Stage one: component products
  always_ff @(posedge clk) begin
    p_xx <= qx * qx;
    p_yy <= qy * qy;
    p_zz <= qz * qz;
    p_xy <= qx * qy;
    p_xz <= qx * qz;
    p_yz <= qy * qz;
    p_wx <= qw * qx;
    p_wy <= qw * qy;
    p_wz <= qw * qz;
  end

  // Stage two: combine, round to 2^-16
  always_ff @(posedge clk) begin
    mat[0][0] <= rnd(DIAG_BIAS - ((wide(p_yy) + wide(p_zz)) <<< 1));
    mat[0][1] <= rnd(ROUND_BIAS + ((wide(p_xy) - wide(p_wz)) <<< 1));
    mat[0][2] <= rnd(ROUND_BIAS + ((wide(p_xz) + wide(p_wy)) <<< 1));
    mat[1][0] <= rnd(ROUND_BIAS + ((wide(p_xy) + wide(p_wz)) <<< 1));
    mat[1][1] <= rnd(DIAG_BIAS - ((wide(p_xx) + wide(p_zz)) <<< 1));
    mat[1][2] <= rnd(ROUND_BIAS + ((wide(p_yz) - wide(p_wx)) <<< 1));
    mat[2][0] <= rnd(ROUND_BIAS + ((wide(p_xz) - wide(p_wy)) <<< 1));
    mat[2][1] <= rnd(ROUND_BIAS + ((wide(p_yz) + wide(p_wx)) <<< 1));
    mat[2][2] <= rnd(DIAG_BIAS - ((wide(p_xx) + wide(p_yy)) <<< 1));
  end

endmodule

>>> src/obm_box_test.sv
module obm_box_test #(
  parameter int COORD_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [obm_pkg::IDX_W-1:0]        in_idx,
  input  logic signed [COORD_BITS-1:0]     pos_x,
  input  logic signed [COORD_BITS-1:0]     pos_y,
  input  logic signed [COORD_BITS-1:0]     pos_z,
  input  logic signed [COORD_BITS-1:0]     center_x,
  input  logic signed [COORD_BITS-1:0]     center_y,
  input  logic signed [COORD_BITS-1:0]     center_z,
  input  logic [COORD_BITS-2:0]            half_x,
  input  logic [COORD_BITS-2:0]            half_y,
  input  logic [COORD_BITS-2:0]            half_z,
  input  obm_pkg::mat_t                    mat,
  output logic                             out_valid,
  output logic [obm_pkg::IDX_W-1:0]        out_idx,
  output logic                             out_inside
);
  import obm_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int PW   = MAT_W + DW;
  localparam int LW   = PW + 2;
  localparam int HW   = CW - 1;
  localparam int LPAD = LW - HW - HALF_SHIFT;

  logic signed [CW-1:0] center [3];
  logic signed [LW-1:0] lim    [3];

  logic                 v1, v2, v3, v4;
  logic [IDX_W-1:0]     idx1, idx2, idx3, idx4;
  logic signed [CW-1:0] pos1 [3];
  logic signed [DW-1:0] d2   [3];
  logic signed [PW-1:0] p3   [3][3];
  logic signed [LW-1:0] l4   [3];
  logic [2:0]           in_axis;

  assign center[0] = center_x;
  assign center[1] = center_y;
  assign center[2] = center_z;
  assign lim[0] = $signed({{LPAD{1'b0}}, half_x, {HALF_SHIFT{1'b0}}});
  assign lim[1] = $signed({{LPAD{1'b0}}, half_y, {HALF_SHIFT{1'b0}}});
  assign lim[2] = $signed({{LPAD{1'b0}}, half_z, {HALF_SHIFT{1'b0}}});

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // Per-axis inclusive bound test on the summed coordinate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_axis[i] = (l4[i] >= -lim[i]) && (l4[i] <= lim[i]);
    end
  end

  // Datapath: capture, offset, products, sums, bound test
  always_ff @(posedge clk) begin
    if (en) begin
      idx1    <= in_idx;
      pos1[0] <= pos_x;
      pos1[1] <= pos_y;
      pos1[2] <= pos_z;

      idx2 <= idx1;
      for (int i = 0; i < 3; i++) begin
        d2[i] <= DW'(pos1[i]) - DW'(center[i]);
      end

      idx3 <= idx2;
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          p3[j][i] <= mat[j][i] * d2[j];
        end
      end

      idx4 <= idx3;
      for (int i = 0; i < 3; i++) begin
        l4[i] <= LW'(p3[0][i]) + LW'(p3[1][i]) + LW'(p3[2][i]);
      end

      out_idx    <= idx4;
      out_inside <= &in_axis;
    end
  end

endmodule

>>> src/oriented_box_entry_exit_monitor.sv
// Oriented box entry and exit monitor.
// Input stream (s_t*): one item per object position sample, carrying the
// object index and its world position. Output stream (m_t*): one item each
// time an object crosses the box boundary, with the object index in tdata
// and the direction in tuser (0 entered, 1 left). Samples that cause no
// crossing, and samples whose index is not below MAX_OBJECTS, give nothing.
// Configuration goes through the APB port: centre, half-extents and the
// rotation quaternion, each at byte address 8*i. Write it only while no item
// is in flight.
// Throughput is one item per clock while the skid entry is empty. A result
// reaches m_tvalid through the five-stage datapath (capture, offset, 9
// parallel multiplies, axis sums, bound test), the per-object inside bitmap
// and the output register. A stalled receiver is absorbed by the output
// register plus one skid entry; s_tready drops only once the skid entry is
// occupied, and the pipeline then holds in place. Reset clears the inside
// bitmap, restores the default box (centre at origin, half-extents of 128
// position steps, identity rotation) and empties the pipeline; s_tready
// rises the cycle after reset is released.
module oriented_box_entry_exit_monitor #(
  parameter int MAX_OBJECTS = 256,
  parameter int COORD_BITS  = 24,
  localparam int IN_TDATA_W = ((obm_pkg::IDX_W + 3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // object_index, pos_x, pos_y, pos_z from the lowest bit up
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [IN_TDATA_W-1:0]           s_tdata,
  // event_object
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [obm_pkg::IDX_W-1:0]       m_tdata,
  // event_kind
  output logic                            m_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [obm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [obm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [obm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import obm_pkg::*;

  localparam int   CW         = COORD_BITS;
  localparam int   FLAG_DEPTH = (MAX_OBJECTS < (1 << IDX_W)) ? MAX_OBJECTS : (1 << IDX_W);
  localparam int   FIW        = $clog2(FLAG_DEPTH);
  localparam logic EV_ENTERED = 1'b0;
  localparam logic EV_LEFT    = 1'b1;

  logic signed [CW-1:0] center_x, center_y, center_z;
  logic [CW-2:0]        half_x, half_y, half_z;
  logic [ROT_W-1:0]     rotation;
  mat_t                 mat;

  logic                 run;
  logic                 en;
  logic                 accept;
  logic [IDX_W-1:0]     in_idx;
  logic                 in_range;

  logic                 t_valid;
  logic [IDX_W-1:0]     t_idx;
  logic                 t_inside;

  logic [FLAG_DEPTH-1:0] inside_flags;
  logic [FIW-1:0]        fidx;
  logic                  was_inside;
  logic                  ev_valid;
  logic                  ev_kind;

  logic                 out_valid;
  logic [IDX_W-1:0]     out_obj;
  logic                 out_kind;
  logic                 skid_valid;
  logic [IDX_W-1:0]     skid_obj;
  logic                 skid_kind;
  logic                 out_free;

  assign pready = 1'b1;

  obm_cfg_regs #(.COORD_BITS(CW)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .center_x (center_x),
    .center_y (center_y),
    .center_z (center_z),
    .half_x   (half_x),
    .half_y   (half_y),
    .half_z   (half_z),
    .rotation (rotation)
  );

  obm_rot_matrix u_mat (
    .clk      (clk),
    .rotation (rotation),
    .mat      (mat)
  );

  // Hold the input closed during reset
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else begin
      run <= 1'b1;
    end
  end

  assign en       = ~skid_valid;
  assign s_tready = run & en;
  assign accept   = s_tvalid & s_tready;
  assign in_idx   = s_tdata[IDX_W-1:0];
  assign in_range = 32'(in_idx) < 32'(MAX_OBJECTS);

  obm_box_test #(.COORD_BITS(CW)) u_test (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (accept & in_range),
    .in_idx     (in_idx),
    .pos_x      ($signed(s_tdata[IDX_W +: CW])),
    .pos_y      ($signed(s_tdata[IDX_W + CW +: CW])),
    .pos_z      ($signed(s_tdata[IDX_W + 2 * CW +: CW])),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .half_x     (half_x),
    .half_y     (half_y),
    .half_z     (half_z),
    .mat        (mat),
    .out_valid  (t_valid),
    .out_idx    (t_idx),
    .out_inside (t_inside)
  );

  // Compare against the stored inside flag
  assign fidx       = t_idx[FIW-1:0];
  assign was_inside = inside_flags[fidx];
  assign ev_valid   = en & t_valid & (t_inside != was_inside);
  assign ev_kind    = t_inside ? EV_ENTERED : EV_LEFT;

  // Update the flag on a crossing
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_flags <= '0;
    end else if (ev_valid) begin
      inside_flags[fidx] <= t_inside;
    end
  end

  // Output register with one skid entry
  assign out_free = ~out_valid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid | ev_valid;
      skid_valid <= 1'b0;
    end else if (ev_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_obj  <= skid_obj;
        out_kind <= skid_kind;
      end else begin
        out_obj  <= t_idx;
        out_kind <= ev_kind;
      end
    end else if (ev_valid) begin
      skid_obj  <= t_idx;
      skid_kind <= ev_kind;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_obj;
  assign m_tuser  = out_kind;

endmodule
